// ===== hdl/swld_pkg.sv =====
package swld_pkg;

   localparam int MAX_PIXELS_DEF = 64;
   localparam int WORD_BITS      = 12;
   localparam int LATCH_CELLS    = 6;

   localparam int MODE_W     = 2;
   localparam int PIX_W      = 8;
   localparam int COLOR_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int PULSE_W    = 4;
   localparam int CELL_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int BIT_W      = 4;
   localparam int IDLE_W     = 4;

   localparam logic [WORD_BITS-1:0] HEADER_WORD = 12'h3AA;
   localparam logic [COUNT_W-1:0]   COUNT_RST   = 7'd8;
   localparam logic [PULSE_W-1:0]   PULSE_RST   = 4'd1;
   localparam logic [CELL_W-1:0]    CELL_RST    = 8'd8;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_BAD_VALUE = 2'd2,
      ST_BUSY      = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PIXEL_COUNT = 2'd0,
      REG_PULSE_TICKS = 2'd1,
      REG_CELL_TICKS  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE        = 2'd0,
      PH_SEND        = 2'd1,
      PH_PIXEL_LATCH = 2'd2,
      PH_FINAL_LATCH = 2'd3
   } phase_type;

endpackage

// ===== hdl/swld_channels.sv =====
interface swld_req_if;
   logic                         valid;
   logic                         ready;
   logic [swld_pkg::MODE_W-1:0]  mode;
   logic [swld_pkg::PIX_W-1:0]   first_pixel;
   logic [swld_pkg::PIX_W-1:0]   last_pixel;
   logic [swld_pkg::COLOR_W-1:0] red;
   logic [swld_pkg::COLOR_W-1:0] green;
   logic [swld_pkg::COLOR_W-1:0] blue;

   modport source (output valid, mode, first_pixel, last_pixel, red, green, blue,
                   input ready);
   modport sink (input valid, mode, first_pixel, last_pixel, red, green, blue,
                 output ready);
endinterface

interface swld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          pin_level;
   logic                          busy_res;
   logic [swld_pkg::STATUS_W-1:0] status;

   modport source (output valid, pin_level, busy_res, status, input ready);
   modport sink (input valid, pin_level, busy_res, status, output ready);
endinterface

interface swld_csr_if;
   logic                            valid;
   logic                            ready;
   logic [swld_pkg::CSR_IDX_W-1:0]  index;
   logic [swld_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/single_wire_led_frame_driver.sv =====
// channel   direction  payload
// req_chan  in         mode, first_pixel, last_pixel, red, green, blue
// rsp_chan  out        pin_level, busy_res, status
// csr_chan  in         index, data (pixel_count, pulse_ticks, cell_ticks)
//
// One request per cycle when not stalled; every request gives one response through an
// output register. A set-range request writes one pixel row of the store per cycle
// after it is taken, so requests stall until its last row is written.
// Reset clears the store at once through per-pixel valid bits.
// A stalled response holds the request side only when the output register is full.
module single_wire_led_frame_driver #(
   parameter int MAX_PIXELS = swld_pkg::MAX_PIXELS_DEF
) (
   input logic clock,
   input logic reset,
   swld_req_if.sink   req_chan,
   swld_rsp_if.source rsp_chan,
   swld_csr_if.sink   csr_chan
);

   localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int PW    = $clog2(MAX_PIXELS + 1);
   localparam int WB    = swld_pkg::WORD_BITS;
   localparam int ROW_W = 3 * WB;
   localparam logic [swld_pkg::BIT_W-1:0]  LAST_BIT = swld_pkg::BIT_W'(WB - 1);
   localparam logic [swld_pkg::IDLE_W-1:0] LATCH    =
      swld_pkg::IDLE_W'(swld_pkg::LATCH_CELLS);

   swld_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]                      pixel_index_ff, pixel_index_in;
   logic [1:0]                         word_index_ff, word_index_in;
   logic [swld_pkg::BIT_W-1:0]         bit_index_ff, bit_index_in;
   logic [swld_pkg::CELL_W-1:0]        cell_tick_ff, cell_tick_in;
   logic [swld_pkg::IDLE_W-1:0]        idle_left_ff, idle_left_in;
   logic [WB-1:0]                      word_shift_ff, word_shift_in;
   logic                               line_ff, line_in;
   logic                               filling_ff, filling_in;
   logic [AW-1:0]                      fill_idx_ff, fill_idx_in;
   logic [AW-1:0]                      fill_last_ff, fill_last_in;
   logic [ROW_W-1:0]                   fill_row_ff, fill_row_in;
   logic [MAX_PIXELS-1:0]              valid_ff, valid_in;
   logic [ROW_W-1:0]                   rd_row_ff;
   logic                               rd_valid_ff;
   logic [swld_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [swld_pkg::PULSE_W-1:0]       pulse_ff, pulse_in;
   logic [swld_pkg::CELL_W-1:0]        cell_ff, cell_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_pin_ff, rsp_pin_in;
   logic                               rsp_busy_ff, rsp_busy_in;
   logic [swld_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic [ROW_W-1:0]             store_mem [MAX_PIXELS];

   logic                         req_ready;
   logic                         accept;
   logic [swld_pkg::PULSE_W-1:0] pulse;
   logic [5:0]                   p2, p3;
   logic [swld_pkg::CELL_W-1:0]  cell_len;
   logic                         level;
   logic [swld_pkg::CELL_W:0]    tick_nx;
   logic                         wrap;
   logic [PW-1:0]                eff_count;
   logic [PW-1:0]                pix_nx;
   logic [WB-1:0]                load_word;
   logic [swld_pkg::IDLE_W-1:0]  left_dec;
   logic                         bad_range;
   logic                         bad_value;

   assign req_ready      = !filling_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pin_level = rsp_pin_ff;
   assign rsp_chan.busy_res  = rsp_busy_ff;
   assign rsp_chan.status    = rsp_status_ff;

   always_comb begin
      pulse    = (pulse_ff == '0) ? swld_pkg::PULSE_W'(1) : pulse_ff;
      p2       = {1'b0, pulse, 1'b0};
      p3       = p2 + {2'b00, pulse};
      cell_len = (cell_ff < {2'b00, p3}) ? {2'b00, p3} : cell_ff;
      level    = (phase_ff == swld_pkg::PH_SEND) &&
                 (({2'b00, cell_tick_ff} < {4'b0000, pulse}) ||
                  (word_shift_ff[WB-1] && ({2'b00, cell_tick_ff} >= {2'b00, p2}) &&
                   ({2'b00, cell_tick_ff} < {2'b00, p3})));
      tick_nx  = {1'b0, cell_tick_ff} + 9'd1;
      wrap     = tick_nx >= {1'b0, cell_len};
      eff_count = (9'(count_ff) > 9'(MAX_PIXELS)) ? PW'(MAX_PIXELS) : PW'(count_ff);
      pix_nx   = pixel_index_ff + PW'(1);
      left_dec = (idle_left_ff != '0) ? idle_left_ff - 1'b1 : idle_left_ff;
      case (word_index_ff)
         2'd0:    load_word = rd_row_ff[WB-1:0];
         2'd1:    load_word = rd_row_ff[2*WB-1:WB];
         default: load_word = rd_row_ff[3*WB-1:2*WB];
      endcase
      if (!rd_valid_ff) load_word = '0;
      bad_range = (9'(req_chan.first_pixel) >= 9'(eff_count)) ||
                  (9'(req_chan.last_pixel) >= 9'(eff_count));
      bad_value = (req_chan.red[swld_pkg::COLOR_W-1:WB] != '0) ||
                  (req_chan.green[swld_pkg::COLOR_W-1:WB] != '0) ||
                  (req_chan.blue[swld_pkg::COLOR_W-1:WB] != '0);

      phase_in       = phase_ff;
      pixel_index_in = pixel_index_ff;
      word_index_in  = word_index_ff;
      bit_index_in   = bit_index_ff;
      cell_tick_in   = cell_tick_ff;
      idle_left_in   = idle_left_ff;
      word_shift_in  = word_shift_ff;
      line_in        = line_ff;
      filling_in     = filling_ff;
      fill_idx_in    = fill_idx_ff;
      fill_last_in   = fill_last_ff;
      fill_row_in    = fill_row_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      pulse_in       = pulse_ff;
      cell_in        = cell_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pin_in     = rsp_pin_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            swld_pkg::REG_PIXEL_COUNT: count_in = csr_chan.data[swld_pkg::COUNT_W-1:0];
            swld_pkg::REG_PULSE_TICKS: pulse_in = csr_chan.data[swld_pkg::PULSE_W-1:0];
            swld_pkg::REG_CELL_TICKS:  cell_in  = csr_chan.data;
            default: ;
         endcase
      end

      if (filling_ff) begin
         valid_in[fill_idx_ff] = 1'b1;
         fill_idx_in = fill_idx_ff + AW'(1);
         if (fill_idx_ff == fill_last_ff) filling_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = swld_pkg::ST_OK;
         case (req_chan.mode)
            swld_pkg::MODE_TICK: begin
               if (phase_ff == swld_pkg::PH_IDLE) begin
                  line_in = 1'b0;
               end else begin
                  line_in      = level;
                  cell_tick_in = tick_nx[swld_pkg::CELL_W-1:0];
                  if (wrap) begin
                     cell_tick_in = '0;
                     case (phase_ff)
                        swld_pkg::PH_SEND: begin
                           word_shift_in = {word_shift_ff[WB-2:0], 1'b0};
                           bit_index_in  = bit_index_ff + 1'b1;
                           if (bit_index_ff == LAST_BIT) begin
                              bit_index_in = '0;
                              if (word_index_ff == 2'd3) begin
                                 phase_in     = swld_pkg::PH_PIXEL_LATCH;
                                 idle_left_in = LATCH;
                              end else begin
                                 word_index_in = word_index_ff + 1'b1;
                                 word_shift_in = load_word;
                              end
                           end
                        end
                        swld_pkg::PH_PIXEL_LATCH: begin
                           idle_left_in = left_dec;
                           if (left_dec == '0) begin
                              pixel_index_in = pix_nx;
                              if (pix_nx >= eff_count) begin
                                 phase_in     = swld_pkg::PH_FINAL_LATCH;
                                 idle_left_in = LATCH;
                              end else begin
                                 phase_in      = swld_pkg::PH_SEND;
                                 word_index_in = '0;
                                 bit_index_in  = '0;
                                 word_shift_in = swld_pkg::HEADER_WORD;
                              end
                           end
                        end
                        swld_pkg::PH_FINAL_LATCH: begin
                           idle_left_in = left_dec;
                           if (left_dec == '0) phase_in = swld_pkg::PH_IDLE;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            swld_pkg::MODE_SET, swld_pkg::MODE_CLEAR: begin
               if (phase_ff != swld_pkg::PH_IDLE) begin
                  rsp_status_in = swld_pkg::ST_BUSY;
               end else if ((req_chan.mode == swld_pkg::MODE_SET) && bad_range) begin
                  rsp_status_in = swld_pkg::ST_BAD_RANGE;
               end else if ((req_chan.mode == swld_pkg::MODE_SET) && bad_value) begin
                  rsp_status_in = swld_pkg::ST_BAD_VALUE;
               end else begin
                  if (req_chan.mode == swld_pkg::MODE_CLEAR) begin
                     valid_in = '0;
                  end else if (req_chan.last_pixel >= req_chan.first_pixel) begin
                     filling_in   = 1'b1;
                     fill_idx_in  = req_chan.first_pixel[AW-1:0];
                     fill_last_in = req_chan.last_pixel[AW-1:0];
                     fill_row_in  = {req_chan.red[WB-1:0], req_chan.green[WB-1:0],
                                     req_chan.blue[WB-1:0]};
                  end
                  pixel_index_in = '0;
                  cell_tick_in   = '0;
                  if (eff_count == '0) begin
                     phase_in     = swld_pkg::PH_FINAL_LATCH;
                     idle_left_in = LATCH;
                  end else begin
                     phase_in      = swld_pkg::PH_SEND;
                     word_index_in = '0;
                     bit_index_in  = '0;
                     word_shift_in = swld_pkg::HEADER_WORD;
                  end
               end
            end
            default: ;
         endcase
         rsp_pin_in  = line_in;
         rsp_busy_in = (phase_in != swld_pkg::PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= swld_pkg::PH_IDLE;
         pixel_index_ff <= '0;
         word_index_ff  <= '0;
         bit_index_ff   <= '0;
         cell_tick_ff   <= '0;
         idle_left_ff   <= '0;
         word_shift_ff  <= '0;
         line_ff        <= 1'b0;
         filling_ff     <= 1'b0;
         valid_ff       <= '0;
         count_ff       <= swld_pkg::COUNT_RST;
         pulse_ff       <= swld_pkg::PULSE_RST;
         cell_ff        <= swld_pkg::CELL_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pixel_index_ff <= pixel_index_in;
         word_index_ff  <= word_index_in;
         bit_index_ff   <= bit_index_in;
         cell_tick_ff   <= cell_tick_in;
         idle_left_ff   <= idle_left_in;
         word_shift_ff  <= word_shift_in;
         line_ff        <= line_in;
         filling_ff     <= filling_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         pulse_ff       <= pulse_in;
         cell_ff        <= cell_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff   <= fill_idx_in;
      fill_last_ff  <= fill_last_in;
      fill_row_ff   <= fill_row_in;
      rsp_pin_ff    <= rsp_pin_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_status_ff <= rsp_status_in;
      rd_valid_ff   <= valid_ff[pixel_index_ff[AW-1:0]];
   end

   // pixel store, one row per pixel: {red, green, blue}
   always_ff @(posedge clock) begin
      if (filling_ff) store_mem[fill_idx_ff] <= fill_row_ff;
      rd_row_ff <= store_mem[pixel_index_ff[AW-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_fill_at_first_pixel: assert property (@(posedge clock) disable iff (reset)
      filling_ff |-> (phase_ff == swld_pkg::PH_SEND) && (pixel_index_ff == '0))
      else $error("store fill overlaps waveform progress");
   a_idle_no_latch: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == swld_pkg::PH_IDLE) |-> (idle_left_ff == '0))
      else $error("idle with latch cells pending");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= LAST_BIT)
      else $error("bit index past word end");
`endif

endmodule
